// ===== rtl/core/assert_macros.svh =====
// Assertion helper macros for the note controller RTL.
// Needs clk_i and rst_ni in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge, off while reset is low
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked at every rising edge, off while reset is low
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

// ===== rtl/core/pnc_pkg.sv =====
// Shared types, constants and note math of the performance note controller.
// No dependencies; used by every module of the block.
`default_nettype none

package pnc_pkg;

  localparam int STICK_BITS_DEF = 12;

  localparam logic [6:0] VEL_BUTTON = 7'd115;
  localparam logic [6:0] VEL_RETUNE = 7'd114;
  localparam logic [6:0] VEL_ARP    = 7'd100;
  localparam logic [6:0] VEL_SNARE  = 7'd120;
  localparam logic [6:0] SNARE_NOTE = 7'd38;
  localparam logic [3:0] CH_SCALE   = 4'd0;
  localparam logic [3:0] CH_ARP     = 4'd1;
  localparam logic [3:0] CH_SNARE   = 4'd9;
  localparam logic [15:0] HOLD_LATCH = 16'hFFFF;

  localparam logic [10:0] ZONE_ENTER_RST = 11'd860;
  localparam logic [10:0] ZONE_EXIT_RST  = 11'd573;
  localparam logic [7:0]  ARP_STEP_RST   = 8'd24;
  localparam logic [15:0] ARP_HOLD_RST   = 16'd112;

  localparam logic [2:0] OCTAVE_RST = 3'd4;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_ZONE_ENTER = 2'd0,
    REG_ZONE_EXIT  = 2'd1,
    REG_ARP_STEP   = 2'd2,
    REG_ARP_HOLD   = 2'd3
  } reg_idx_e;

  // Zones
  typedef enum logic [1:0] {
    ZONE_CENTER = 2'd0,
    ZONE_HIGH   = 2'd1,
    ZONE_ACC    = 2'd2,
    ZONE_LOW    = 2'd3
  } zone_e;

  // Waveforms
  typedef enum logic [1:0] {
    WAVE_SIN = 2'd0,
    WAVE_SQR = 2'd1,
    WAVE_SAW = 2'd2,
    WAVE_TRI = 2'd3
  } wave_e;

  // Event kinds
  localparam logic EV_OFF = 1'b0;
  localparam logic EV_ON  = 1'b1;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ZONE,
    OP_RET_OFF,
    OP_RET_ON,
    OP_BTN,
    OP_OCT,
    OP_MISC,
    OP_SNARE,
    OP_ARP_EVAL,
    OP_ARP_OFF,
    OP_ARP_ON
  } op_e;

  typedef struct packed {
    logic       kind;
    logic [3:0] ch;
    logic [6:0] note;
    logic [6:0] vel;
    logic [1:0] wave;
  } ev_t;

  typedef struct packed {
    op_e        op;
    logic [1:0] idx;
    logic       fire;
    logic       load;
  } cmd_t;

  typedef struct packed {
    logic zone_chg;
    logic oct_step;
    logic arp_tick;
  } dp_status_t;

  typedef struct packed {
    logic can_take;
    logic flush_ok;
    logic pend_valid;
  } st_status_t;

  // Per-zone, per-button semitone offsets
  localparam logic signed [4:0] NOTE_OFS [4][4] = '{
    '{5'sd0,  5'sd2,  5'sd4,  5'sd5},
    '{5'sd7,  5'sd9,  5'sd11, 5'sd12},
    '{5'sd1,  5'sd3,  5'sd6,  5'sd8},
    '{-5'sd5, -5'sd3, -5'sd1, 5'sd0}
  };

  // 12*(oct+1) + offset, clamped to 0..127
  function automatic logic [6:0] calc_note(logic [2:0] oct, logic [1:0] z, logic [1:0] i);
    logic [3:0]        o1;
    logic [8:0]        base;
    logic signed [4:0] ofs;
    logic signed [9:0] n;
    o1   = {1'b0, oct} + 4'd1;
    base = 9'(o1) * 9'd12;
    ofs  = NOTE_OFS[z][i];
    n    = $signed({1'b0, base}) + $signed({{5{ofs[4]}}, ofs});
    if (n < 0) begin
      return 7'd0;
    end else if (n > 10'sd127) begin
      return 7'd127;
    end
    return n[6:0];
  endfunction

  // square -> saw -> sine -> triangle -> square
  function automatic logic [1:0] next_wave(logic [1:0] w);
    logic [1:0] r;
    unique case (w)
      WAVE_SQR: r = WAVE_SAW;
      WAVE_SAW: r = WAVE_SIN;
      WAVE_SIN: r = WAVE_TRI;
      default:  r = WAVE_SQR;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pnc_out_stage.sv =====
// Output staging: one pending word plus the output register, so that the
// final word of a frame can be marked. Depends on pnc_pkg.
`default_nettype none

module pnc_out_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire pnc_pkg::ev_t  ev_i,
  input  wire logic          flush_i,
  output pnc_pkg::st_status_t status_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output pnc_pkg::ev_t       out_ev_o,
  output logic               out_last_o
);
  import pnc_pkg::*;

  ev_t  pend_q, out_q;
  logic pend_v_q, out_v_q, last_q;
  logic out_free, move, move_last;

  assign out_free  = !out_v_q || out_ready_i;
  assign move      = push_i && pend_v_q;
  assign move_last = flush_i && pend_v_q && out_free;

  assign status_o.can_take   = !pend_v_q || out_free;
  assign status_o.flush_ok   = !pend_v_q || out_free;
  assign status_o.pend_valid = pend_v_q;

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (push_i) begin
        pend_v_q <= 1'b1;
      end else if (move_last) begin
        pend_v_q <= 1'b0;
      end
      if (move || move_last) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      pend_q <= ev_i;
    end
    if (move || move_last) begin
      out_q  <= pend_q;
      last_q <= move_last;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_ev_o    = out_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

// ===== rtl/core/pnc_datapath.sv =====
// Datapath: frame registers, config registers, note state and event building.
// Depends on pnc_pkg; driven by commands from pnc_ctrl.
`default_nettype none

module pnc_datapath #(
  parameter int StickBits = pnc_pkg::STICK_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire pnc_pkg::cmd_t        cmd_i,
  output pnc_pkg::dp_status_t       status_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_idx_i,
  input  wire logic [15:0]          cfg_wdata_i,
  input  wire logic [4:0]           held_buttons_i,
  input  wire logic                 stick_press_edge_i,
  input  wire logic                 octave_step_i,
  input  wire logic                 wave_step_i,
  input  wire logic signed [StickBits-1:0] stick_x_i,
  input  wire logic signed [StickBits-1:0] stick_y_i,
  output logic                      push_o,
  output pnc_pkg::ev_t              ev_o
);
  import pnc_pkg::*;

  localparam int CW     = ((StickBits > 12) ? StickBits : 12) + 2;
  localparam int ThrShl = (StickBits >= 12) ? (StickBits - 12) : 0;
  localparam int ThrShr = (StickBits < 12) ? (12 - StickBits) : 0;

  // Config registers
  logic [10:0] zone_enter_q, zone_exit_q;
  logic [7:0]  arp_step_q;
  logic [15:0] arp_hold_q;

  // Frame registers
  logic [4:0] btn_q;
  logic       edge_q, ostep_q, wstep_q;
  logic signed [StickBits-1:0] x_q, y_q;

  // Note state
  logic [1:0]  zone_q;
  logic [3:0]  held_q;
  logic [6:0]  bn_q [4];
  logic [2:0]  oct_q, ret_oct_q;
  logic [1:0]  wave_q;
  logic        arp_on_q, arp_down_q;
  logic [6:0]  arp_prev_q;
  logic [1:0]  arp_idx_q;
  logic [7:0]  arp_fc_q;
  logic [15:0] hold_q;

  // Zone selection
  logic signed [CW-1:0] xs, ys, en_s, ex_s;
  logic [1:0] nz;

  assign xs   = CW'(x_q);
  assign ys   = CW'(y_q);
  assign en_s = $signed((CW'(zone_enter_q) << ThrShl) >> ThrShr);
  assign ex_s = $signed((CW'(zone_exit_q) << ThrShl) >> ThrShr);

  always_comb begin
    priority if (zone_q == ZONE_HIGH && (xs > ex_s || ys > ex_s)) begin
      nz = ZONE_HIGH;
    end else if (zone_q == ZONE_ACC && xs < -ex_s) begin
      nz = ZONE_ACC;
    end else if (zone_q == ZONE_LOW && ys < -ex_s) begin
      nz = ZONE_LOW;
    end else if (xs > en_s || ys > en_s) begin
      nz = ZONE_HIGH;
    end else if (xs < -en_s) begin
      nz = ZONE_ACC;
    end else if (ys < -en_s) begin
      nz = ZONE_LOW;
    end else begin
      nz = ZONE_CENTER;
    end
  end

  // Note selection for the slot in the command
  logic [6:0] old_n, ret_n, btn_n;
  assign old_n = bn_q[cmd_i.idx];
  assign ret_n = calc_note(ret_oct_q, zone_q, cmd_i.idx);
  assign btn_n = calc_note(oct_q, zone_q, cmd_i.idx);

  // Arpeggiator: rank of each stored note in ascending order
  logic [1:0] rank [4];
  logic [2:0] cnt;
  logic [6:0] arp_note;
  always_comb begin
    cnt      = 3'd0;
    arp_note = 7'd0;
    for (int i = 0; i < 4; i++) begin
      rank[i] = 2'd0;
      if (bn_q[i] != 7'd0) begin
        cnt = cnt + 3'd1;
      end
      for (int j = 0; j < 4; j++) begin
        if (bn_q[j] != 7'd0 && j != i) begin
          if ((j < i && bn_q[j] <= bn_q[i]) || (j > i && bn_q[j] < bn_q[i])) begin
            rank[i] = rank[i] + 2'd1;
          end
        end
      end
    end
    for (int i = 0; i < 4; i++) begin
      if (bn_q[i] != 7'd0 && rank[i] == arp_idx_q) begin
        arp_note = bn_q[i];
      end
    end
  end

  logic       arp_act;
  logic [7:0] fc_n;
  assign arp_act = arp_on_q && (held_q != 4'd0);
  assign fc_n    = arp_fc_q + 8'd1;

  assign status_o.zone_chg = (nz != zone_q);
  assign status_o.oct_step = ostep_q;
  assign status_o.arp_tick = arp_act && (fc_n >= arp_step_q) && (cnt != 3'd0);

  // Event built by the current operation
  always_comb begin
    push_o    = 1'b0;
    ev_o.kind = EV_OFF;
    ev_o.ch   = CH_SCALE;
    ev_o.note = 7'd0;
    ev_o.vel  = 7'd0;
    ev_o.wave = wave_q;
    unique case (cmd_i.op)
      OP_RET_OFF: begin
        push_o    = (old_n != 7'd0) && (old_n != ret_n);
        ev_o.note = old_n;
      end
      OP_RET_ON: begin
        push_o    = (old_n != 7'd0) && (old_n != ret_n);
        ev_o.kind = EV_ON;
        ev_o.note = ret_n;
        ev_o.vel  = VEL_RETUNE;
      end
      OP_BTN: begin
        if (btn_q[cmd_i.idx] && !held_q[cmd_i.idx]) begin
          push_o    = 1'b1;
          ev_o.kind = EV_ON;
          ev_o.note = btn_n;
          ev_o.vel  = VEL_BUTTON;
        end else if (!btn_q[cmd_i.idx] && held_q[cmd_i.idx]) begin
          push_o    = (old_n != 7'd0);
          ev_o.note = old_n;
        end
      end
      OP_SNARE: begin
        push_o    = edge_q;
        ev_o.kind = EV_ON;
        ev_o.ch   = CH_SNARE;
        ev_o.note = SNARE_NOTE;
        ev_o.vel  = VEL_SNARE;
      end
      OP_ARP_EVAL: begin
        push_o    = !arp_act && (arp_prev_q != 7'd0);
        ev_o.ch   = CH_ARP;
        ev_o.note = arp_prev_q;
      end
      OP_ARP_OFF: begin
        push_o    = (arp_prev_q != 7'd0);
        ev_o.ch   = CH_ARP;
        ev_o.note = arp_prev_q;
      end
      OP_ARP_ON: begin
        push_o    = 1'b1;
        ev_o.kind = EV_ON;
        ev_o.ch   = CH_ARP;
        ev_o.note = arp_note;
        ev_o.vel  = VEL_ARP;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
    push_o = push_o && cmd_i.fire;
  end

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_enter_q <= ZONE_ENTER_RST;
      zone_exit_q  <= ZONE_EXIT_RST;
      arp_step_q   <= ARP_STEP_RST;
      arp_hold_q   <= ARP_HOLD_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_ZONE_ENTER: zone_enter_q <= cfg_wdata_i[10:0];
        REG_ZONE_EXIT:  zone_exit_q  <= cfg_wdata_i[10:0];
        REG_ARP_STEP:   arp_step_q   <= cfg_wdata_i[7:0];
        default:        arp_hold_q   <= cfg_wdata_i;
      endcase
    end
  end

  // Frame capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      btn_q   <= held_buttons_i;
      edge_q  <= stick_press_edge_i;
      ostep_q <= octave_step_i;
      wstep_q <= wave_step_i;
      x_q     <= stick_x_i;
      y_q     <= stick_y_i;
    end
  end

  // Next arp position after a played note
  logic [2:0] ix_up;
  assign ix_up = {1'b0, arp_idx_q} + 3'd1;

  // Note state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q     <= ZONE_CENTER;
      held_q     <= 4'd0;
      for (int i = 0; i < 4; i++) begin
        bn_q[i] <= 7'd0;
      end
      oct_q      <= OCTAVE_RST;
      ret_oct_q  <= OCTAVE_RST;
      wave_q     <= WAVE_SQR;
      arp_on_q   <= 1'b0;
      arp_down_q <= 1'b0;
      arp_prev_q <= 7'd0;
      arp_idx_q  <= 2'd0;
      arp_fc_q   <= 8'd0;
      hold_q     <= 16'd0;
    end else if (cmd_i.fire) begin
      unique case (cmd_i.op)
        OP_ZONE: begin
          zone_q    <= nz;
          ret_oct_q <= oct_q;
        end
        OP_RET_ON: begin
          if (old_n != 7'd0) begin
            bn_q[cmd_i.idx] <= ret_n;
          end
        end
        OP_BTN: begin
          if (btn_q[cmd_i.idx] && !held_q[cmd_i.idx]) begin
            bn_q[cmd_i.idx]   <= btn_n;
            held_q[cmd_i.idx] <= 1'b1;
          end else if (!btn_q[cmd_i.idx] && held_q[cmd_i.idx]) begin
            bn_q[cmd_i.idx]   <= 7'd0;
            held_q[cmd_i.idx] <= 1'b0;
          end
        end
        OP_OCT: begin
          if (ostep_q) begin
            if (oct_q >= 3'd5) begin
              oct_q     <= 3'd3;
              ret_oct_q <= 3'd3;
            end else begin
              oct_q     <= oct_q + 3'd1;
              ret_oct_q <= oct_q + 3'd1;
            end
          end
        end
        OP_MISC: begin
          if (wstep_q) begin
            wave_q <= next_wave(wave_q);
          end
          // long hold of the stick press toggles the arpeggiator
          if (btn_q[4]) begin
            if (hold_q != HOLD_LATCH) begin
              if (hold_q + 16'd1 == arp_hold_q) begin
                arp_on_q   <= !arp_on_q;
                arp_idx_q  <= 2'd0;
                arp_down_q <= 1'b0;
                hold_q     <= HOLD_LATCH;
              end else begin
                hold_q <= hold_q + 16'd1;
              end
            end
          end else begin
            hold_q <= 16'd0;
          end
        end
        OP_ARP_EVAL: begin
          if (!arp_act) begin
            arp_prev_q <= 7'd0;
            arp_idx_q  <= 2'd0;
            arp_down_q <= 1'b0;
            arp_fc_q   <= 8'd0;
          end else if (fc_n < arp_step_q) begin
            arp_fc_q <= fc_n;
          end else begin
            arp_fc_q <= 8'd0;
            // pull an out-of-range index back to the top note
            if (cnt != 3'd0 && {1'b0, arp_idx_q} >= cnt) begin
              arp_idx_q <= (cnt > 3'd1) ? 2'(cnt - 3'd1) : 2'd0;
            end
          end
        end
        OP_ARP_ON: begin
          arp_prev_q <= arp_note;
          if (arp_down_q) begin
            if (arp_idx_q == 2'd0) begin
              arp_idx_q  <= (cnt > 3'd1) ? 2'd1 : 2'd0;
              arp_down_q <= 1'b0;
            end else begin
              arp_idx_q <= arp_idx_q - 2'd1;
            end
          end else if (ix_up >= cnt) begin
            arp_idx_q  <= (cnt > 3'd1) ? 2'(cnt - 3'd2) : 2'd0;
            arp_down_q <= 1'b1;
          end else begin
            arp_idx_q <= ix_up[1:0];
          end
        end
        default: begin
          arp_fc_q <= arp_fc_q;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pnc_ctrl.sv =====
// Controller: sequences the processing steps of one frame.
// Depends on pnc_pkg; commands pnc_datapath and pnc_out_stage.
`default_nettype none

module pnc_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire pnc_pkg::dp_status_t dp_status_i,
  input  wire pnc_pkg::st_status_t st_status_i,
  output pnc_pkg::cmd_t            cmd_o,
  output logic                     flush_o
);
  import pnc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ZONE, S_RET_OFF, S_RET_ON, S_BTN, S_OCT, S_MISC,
    S_SNARE, S_ARP_EVAL, S_ARP_OFF, S_ARP_ON, S_FLUSH
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] idx_q, idx_d;
  logic       from_oct_q, from_oct_d;
  logic       step;

  // Command decode
  always_comb begin
    cmd_o.idx = idx_q;
    unique case (state_q)
      S_ZONE:     cmd_o.op = OP_ZONE;
      S_RET_OFF:  cmd_o.op = OP_RET_OFF;
      S_RET_ON:   cmd_o.op = OP_RET_ON;
      S_BTN:      cmd_o.op = OP_BTN;
      S_OCT:      cmd_o.op = OP_OCT;
      S_MISC:     cmd_o.op = OP_MISC;
      S_SNARE:    cmd_o.op = OP_SNARE;
      S_ARP_EVAL: cmd_o.op = OP_ARP_EVAL;
      S_ARP_OFF:  cmd_o.op = OP_ARP_OFF;
      S_ARP_ON:   cmd_o.op = OP_ARP_ON;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o.load = in_valid_i && in_ready_o;
  assign step       = (state_q != S_IDLE) && (state_q != S_FLUSH) && st_status_i.can_take;
  assign cmd_o.fire = step;
  assign flush_o    = (state_q == S_FLUSH);

  // Next step
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    from_oct_d = from_oct_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_ZONE;
        end
      end
      S_FLUSH: begin
        if (st_status_i.flush_ok) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        if (step) begin
          unique case (state_q)
            S_ZONE: begin
              idx_d      = 2'd0;
              from_oct_d = 1'b0;
              state_d    = dp_status_i.zone_chg ? S_RET_OFF : S_BTN;
            end
            S_RET_OFF: state_d = S_RET_ON;
            S_RET_ON: begin
              idx_d = idx_q + 2'd1;
              if (idx_q != 2'd3) begin
                state_d = S_RET_OFF;
              end else begin
                state_d = from_oct_q ? S_MISC : S_BTN;
              end
            end
            S_BTN: begin
              idx_d = idx_q + 2'd1;
              if (idx_q == 2'd3) begin
                state_d = S_OCT;
              end
            end
            S_OCT: begin
              idx_d      = 2'd0;
              from_oct_d = 1'b1;
              state_d    = dp_status_i.oct_step ? S_RET_OFF : S_MISC;
            end
            S_MISC:     state_d = S_SNARE;
            S_SNARE:    state_d = S_ARP_EVAL;
            S_ARP_EVAL: state_d = dp_status_i.arp_tick ? S_ARP_OFF : S_FLUSH;
            S_ARP_OFF:  state_d = S_ARP_ON;
            default:    state_d = S_FLUSH;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      idx_q      <= 2'd0;
      from_oct_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      from_oct_q <= from_oct_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/performance_note_controller_top.sv =====
// Performance note controller: one control frame in, a run of note events out,
// the final event of each frame marked by last_o. A frame runs through these
// processing steps in order: zone, up to 8 retune steps after a zone change,
// 4 buttons, octave, up to 8 retune steps after an octave step, wave and hold,
// snare, one to 3 arpeggiator steps and end of frame; a step waits while the
// event output is stalled.
// A new frame is taken only once the previous one has been fully queued.
// Depends on pnc_pkg, pnc_ctrl, pnc_datapath, pnc_out_stage, assert_macros.svh.
`default_nettype none

module performance_note_controller_top #(
  parameter int StickBits = pnc_pkg::STICK_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_idx_i,
  input  wire logic [15:0]          cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [4:0]           held_buttons_i,
  input  wire logic                 stick_press_edge_i,
  input  wire logic                 octave_step_i,
  input  wire logic                 wave_step_i,
  input  wire logic signed [StickBits-1:0] stick_x_i,
  input  wire logic signed [StickBits-1:0] stick_y_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      event_kind_o,
  output logic [3:0]                channel_o,
  output logic [6:0]                note_o,
  output logic [6:0]                velocity_o,
  output logic [1:0]                waveform_o,
  output logic                      last_o
);
  import pnc_pkg::*;

  cmd_t       cmd;
  dp_status_t dp_st;
  st_status_t st_st;
  logic       push, flush;
  ev_t        ev, out_ev;

  pnc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .dp_status_i (dp_st),
    .st_status_i (st_st),
    .cmd_o       (cmd),
    .flush_o     (flush)
  );

  pnc_datapath #(
    .StickBits (StickBits)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (dp_st),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .held_buttons_i     (held_buttons_i),
    .stick_press_edge_i (stick_press_edge_i),
    .octave_step_i      (octave_step_i),
    .wave_step_i        (wave_step_i),
    .stick_x_i          (stick_x_i),
    .stick_y_i          (stick_y_i),
    .push_o             (push),
    .ev_o               (ev)
  );

  pnc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .ev_i        (ev),
    .flush_i     (flush),
    .status_o    (st_st),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_ev_o    (out_ev),
    .out_last_o  (last_o)
  );

  assign event_kind_o = out_ev.kind;
  assign channel_o    = out_ev.ch;
  assign note_o       = out_ev.note;
  assign velocity_o   = out_ev.vel;
  assign waveform_o   = out_ev.wave;

  // Checks
`include "assert_macros.svh"
  `ASSERT_IMPL(a_push_has_room, push, st_st.can_take, "word pushed with no room in stage")
  `ASSERT_IMPL(a_idle_drained, in_ready_o, !st_st.pend_valid, "idle with a word still pending")
  `ASSERT_CLK(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "frame overlap")

endmodule

`default_nettype wire
